// ----- src/sot_pkg.sv -----
// Shared types and constants for the section offset translator.
`default_nettype none
package sot_pkg;

	localparam int MAX_SECTIONS_DEF = 16;
	localparam int COUNT_W = 5;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_V2F = 2'd1;
	localparam logic [1:0] OP_F2V = 2'd2;

	localparam logic [1:0] ST_PASS = 2'd0;
	localparam logic [1:0] ST_MAPPED = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  entry_index;
		logic [31:0] virtual_start;
		logic [31:0] file_start;
		logic [31:0] query_address;
	} req_t;

	typedef struct packed {
		logic [31:0] translated_address;
		logic [1:0]  match_status;
		logic [3:0]  matched_section;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept_query;
		logic accept_load;
		logic data_vld;
		logic data_first;
		logic data_last;
		logic finish;
	} ctl_t;

endpackage
`default_nettype wire

// ----- src/section_offset_translator.sv -----
// Top level of the section offset translator.
//
// Translates addresses between virtual and file space through a section table.
// The req channel carries transactions: a load writes one table slot, a query
// translates query_address in the direction given by operation. Each query
// gives one rsp transaction; loads and the unused operation code give none.
// cfg_wr_en / cfg_wr_data set section_count; the user must write it only while
// the block is idle, the block itself does not enforce this. A load writes its
// slot at the edge that accepts it. A query passes from acceptance through the
// scan, a drain state and a finish state into the response register (straight
// to the finish state with an empty table); the table lives in two RAMs read
// one entry per cycle, so the scan covers n entries, n being section_count
// clamped to MAX_SECTIONS. req_stall is high while a query is in flight. One
// response waits in the output register: a new transaction is taken while it
// stalls, and a finished query holds until the register is free. Reset clears
// control and section_count; table contents stay undefined until loaded.
`default_nettype none
module section_offset_translator
	import sot_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_t                    rsp,
	input  wire logic               cfg_wr_en,
	input  wire logic [COUNT_W-1:0] cfg_wr_data
);

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int CW = $clog2(MAX_SECTIONS + 1);

	logic [COUNT_W-1:0] count_q;
	logic [CW-1:0]      sec_n;
	logic               rsp_free;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      data_idx;
	ctl_t               ctl;
	logic               wr_en;
	logic [31:0]        vrd;
	logic [31:0]        frd;
	logic [31:0]        src;
	logic [31:0]        dst;
	logic               ge;
	logic [31:0]        off;

	logic [1:0]    op_q;
	logic [31:0]   addr_q;
	logic          pass_q;
	logic          found_q;
	logic [AW-1:0] hit_q;
	logic [31:0]   hit_dst_q;
	logic [31:0]   hit_off_q;
	logic          prev_ge_q;
	logic [31:0]   prev_dst_q;
	logic [31:0]   prev_off_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;

	assign sec_n = (32'(count_q) > 32'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS) : CW'(count_q);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign wr_en = ctl.accept_load && (32'(req.entry_index) < 32'(MAX_SECTIONS));

	sot_ctrl #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.sec_n     (sec_n),
		.rsp_free  (rsp_free),
		.req_stall (req_stall),
		.rd_addr   (rd_addr),
		.data_idx  (data_idx),
		.ctl       (ctl)
	);

	sot_ram #(
		.WIDTH(32),
		.DEPTH(MAX_SECTIONS)
	) u_vstart (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(req.entry_index)),
		.wr_data (req.virtual_start),
		.rd_addr (rd_addr),
		.rd_data (vrd)
	);

	sot_ram #(
		.WIDTH(32),
		.DEPTH(MAX_SECTIONS)
	) u_fstart (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(req.entry_index)),
		.wr_data (req.file_start),
		.rd_addr (rd_addr),
		.rd_data (frd)
	);

	always_comb begin
		src = (op_q == OP_V2F) ? vrd : frd;
		dst = (op_q == OP_V2F) ? frd : vrd;
		ge = (addr_q >= src);
		off = addr_q - src;
	end

	always_comb begin
		if (pass_q) begin
			rsp_d.translated_address = addr_q;
			rsp_d.match_status = ST_PASS;
			rsp_d.matched_section = '0;
		end else if (found_q) begin
			rsp_d.translated_address = hit_dst_q + hit_off_q;
			rsp_d.match_status = ST_MAPPED;
			rsp_d.matched_section = 4'(hit_q);
		end else begin
			rsp_d.translated_address = '0;
			rsp_d.match_status = ST_NONE;
			rsp_d.matched_section = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rsp_q <= rsp_d;
		end
		if (ctl.accept_query) begin
			op_q <= req.operation;
			addr_q <= req.query_address;
			pass_q <= (sec_n == '0);
			found_q <= 1'b0;
		end else if (ctl.data_vld) begin
			prev_ge_q <= ge;
			prev_dst_q <= dst;
			prev_off_q <= off;
			if (ctl.data_first && !ge) begin
				pass_q <= 1'b1;
			end
			if (ctl.data_last && ge) begin
				found_q <= 1'b1;
				hit_q <= data_idx;
				hit_dst_q <= dst;
				hit_off_q <= off;
			end else if (!ctl.data_first && prev_ge_q && !ge) begin
				found_q <= 1'b1;
				hit_q <= AW'(data_idx - 1'b1);
				hit_dst_q <= prev_dst_q;
				hit_off_q <= prev_off_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire

// ----- src/sot_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ----- src/sot_ctrl.sv -----
// Sequencer: accepts transactions and walks the section table addresses.
`default_nettype none
module sot_ctrl
	import sot_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
	localparam int CW = $clog2(MAX_SECTIONS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_op,
	input  wire logic [CW-1:0] sec_n,
	input  wire logic          rsp_free,
	output logic               req_stall,
	output logic [AW-1:0]      rd_addr,
	output logic [AW-1:0]      data_idx,
	output ctl_t               ctl
);

	state_t state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] last_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic          accept;
	logic          is_query;

	assign accept = req_valid && (state_q == S_IDLE);
	assign is_query = (req_op == OP_V2F) || (req_op == OP_F2V);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_query) begin
					state_d = (sec_n == '0) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == last_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != S_IDLE);
		rd_addr = cnt_q;
		data_idx = idx_s1;
		ctl.accept_query = accept && is_query;
		ctl.accept_load = accept && (req_op == OP_LOAD);
		ctl.data_vld = vld_s1;
		ctl.data_first = vld_s1 && (idx_s1 == '0);
		ctl.data_last = vld_s1 && (idx_s1 == last_q);
		ctl.finish = (state_q == S_FINISH) && rsp_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept && is_query) begin
			cnt_q <= '0;
			last_q <= AW'(sec_n - 1'b1);
		end else if (state_q == S_SCAN && cnt_q != last_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> ctl.data_last)
		else $error("last table entry not evaluated in drain");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cnt_q <= last_q)
		else $error("scan address ran past last section");

	a_vld_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q) == S_SCAN)
		else $error("read data flagged valid outside a scan");

endmodule
`default_nettype wire
